// ===== hw/rtl/deq_pkg.sv =====
// Shared types and codes for the double-ended queue unit.
package deq_pkg;

  // Action codes carried on the input tuser
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_LOOK       = 3'd4
  } action_t;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Per-chain control, broadcast to every cell
  typedef struct packed {
    logic insert_head;  // shift toward tail, new value enters cell 0
    logic remove_head;  // shift toward head, cell 0 drops out
    logic append;       // write new value into the cell at the count
  } cell_ctl_t;

endpackage

// ===== hw/rtl/deq_cell.sv =====
// One storage cell of a queue chain: holds one item and trades with its neighbors.
module deq_cell #(
  parameter int IW  = 32,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  deq_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      count,
  input  logic [IW-1:0]      value,
  input  logic [IW-1:0]      prev_data,  // neighbor toward head
  input  logic [IW-1:0]      next_data,  // neighbor toward tail
  output logic [IW-1:0]      data,
  output logic [IW-1:0]      data_next
);

  // Select what this cell holds after the beat
  always_comb begin
    data_next = data;
    if (ctl.insert_head) begin
      data_next = (IDX == 0) ? value : prev_data;
    end else if (ctl.remove_head) begin
      data_next = next_data;
    end else if (ctl.append && (count == CW'(IDX))) begin
      data_next = value;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== hw/rtl/deq_chain.sv =====
// A row of cells with its head at cell 0; one shift or one write per beat.
module deq_chain #(
  parameter int DEPTH = 16,
  parameter int IW    = 32,
  parameter int CW    = 5
) (
  input  logic               clk,
  input  deq_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      count,
  input  logic [IW-1:0]      value,
  output logic [IW-1:0]      head_next
);

  logic [IW-1:0] cell_data [DEPTH];
  logic [IW-1:0] cell_next [DEPTH];

  // Neighbor links; the end cells feed back their own value where unused
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [IW-1:0] prev_link;
    logic [IW-1:0] next_link;

    if (i == 0) begin : g_first
      assign prev_link = cell_data[i];
    end else begin : g_mid
      assign prev_link = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_link = cell_data[i];
    end else begin : g_body
      assign next_link = cell_data[i+1];
    end

    deq_cell #(
      .IW  (IW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .value     (value),
      .prev_data (prev_link),
      .next_data (next_link),
      .data      (cell_data[i]),
      .data_next (cell_next[i])
    );
  end

  assign head_next = cell_next[0];

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// Top level of the bounded double-ended queue: two mirrored cell chains and a result register.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------------------------
//  s_axis   | in  | s_tvalid/s_tready | s_tuser: action; s_tdata: item_value
//  m_axis   | out | m_tvalid/m_tready | m_tdata: status, front, back, is_empty, count
//
// One beat per cycle unless the result stalls: a push shifts one chain and writes the indexed
// cell of the other, a pop shifts one chain, and the result register loads in the same cycle
// the beat is taken. The forward chain keeps the front item in cell 0, the reverse chain keeps
// the back item in cell 0, so both results come from a fixed cell.
// Reset clears the count and the output valid; cell contents are left as they are.
// A stalled result holds the input off until m_tready takes it.
module double_ended_queue_unit #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  // item_value
  input  logic [((ITEM_WIDTH+7)/8)*8-1:0] s_tdata,
  // action
  input  logic [2:0] s_tuser,
  input  logic s_tvalid,
  output logic s_tready,
  // status, front_item, back_item, is_empty, item_count
  output logic [((2*ITEM_WIDTH+2+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
  output logic m_tvalid,
  input  logic m_tready
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int IW  = ITEM_WIDTH;
  localparam int RW  = 2 * IW + 2 + CW;
  localparam int OBW = ((RW + 7) / 8) * 8;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          fire;
  logic          full;
  logic          empty;
  logic          status_next;
  logic [IW-1:0] value;
  logic [IW-1:0] fwd_head_next;
  logic [IW-1:0] rev_head_next;

  deq_pkg::cell_ctl_t fwd_ctl;
  deq_pkg::cell_ctl_t rev_ctl;

  // Result register
  logic          r_status;
  logic [IW-1:0] r_front;
  logic [IW-1:0] r_back;
  logic          r_empty;
  logic [CW-1:0] r_count;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign value    = s_tdata[IW-1:0];

  // Decode the action into chain controls and the new count
  always_comb begin
    fwd_ctl     = '0;
    rev_ctl     = '0;
    status_next = deq_pkg::STATUS_OK;
    count_next  = count;
    case (s_tuser)
      deq_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = deq_pkg::STATUS_FAIL;
        end else begin
          fwd_ctl.insert_head = fire;
          rev_ctl.append      = fire;
          count_next          = count + CW'(1);
        end
      end
      deq_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          status_next = deq_pkg::STATUS_FAIL;
        end else begin
          fwd_ctl.append      = fire;
          rev_ctl.insert_head = fire;
          count_next          = count + CW'(1);
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (empty) begin
          status_next = deq_pkg::STATUS_FAIL;
        end else begin
          fwd_ctl.remove_head = fire;
          count_next          = count - CW'(1);
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        if (empty) begin
          status_next = deq_pkg::STATUS_FAIL;
        end else begin
          rev_ctl.remove_head = fire;
          count_next          = count - CW'(1);
        end
      end
      default: begin
        // look only, and unused codes
        status_next = deq_pkg::STATUS_OK;
      end
    endcase
  end

  // Front at cell 0 of the forward chain
  deq_chain #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_fwd (
    .clk       (clk),
    .ctl       (fwd_ctl),
    .count     (count),
    .value     (value),
    .head_next (fwd_head_next)
  );

  // Back at cell 0 of the reverse chain
  deq_chain #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_rev (
    .clk       (clk),
    .ctl       (rev_ctl),
    .count     (count),
    .value     (value),
    .head_next (rev_head_next)
  );

  // Count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload, zeroed items when the queue ends up empty
  always_ff @(posedge clk) begin
    if (fire) begin
      r_status <= status_next;
      r_count  <= count_next;
      r_empty  <= (count_next == '0);
      r_front  <= (count_next == '0) ? '0 : fwd_head_next;
      r_back   <= (count_next == '0) ? '0 : rev_head_next;
    end
  end

  assign m_tdata = OBW'({r_count, r_empty, r_back, r_front, r_status});

endmodule

// ===== hw/rtl/deq_checker.sv =====
// Port-level checks for the double-ended queue unit, bound to the top level.
module deq_checker #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  input logic [((2*ITEM_WIDTH+2+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
  input logic m_tvalid,
  input logic m_tready
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = ITEM_WIDTH;

  logic [IW-1:0] front;
  logic [IW-1:0] back;
  logic          is_empty;
  logic [CW-1:0] count;

  assign front    = m_tdata[IW:1];
  assign back     = m_tdata[2*IW:IW+1];
  assign is_empty = m_tdata[2*IW+1];
  assign count    = m_tdata[2*IW+1+CW:2*IW+2];

  // A stalled result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Empty flag agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (is_empty == (count == '0)))
    else $error("empty flag and count disagree");

  // Empty queue reports zero items, and the count never passes the depth
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!is_empty || (front == '0 && back == '0)) && (count <= CW'(DEPTH)))
    else $error("empty result with items or count beyond depth");

  // With a single item, front and back are the same entry
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (count == CW'(1)) |-> (front == back))
    else $error("single item shows different front and back");

  // Count moves by at most one between consecutive results
  a_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready ##1 m_tvalid && !$stable(m_tdata) |->
      (count == $past(count)) || (count == $past(count) + CW'(1)) ||
      (count == $past(count) - CW'(1)))
    else $error("count jumped by more than one");

endmodule

bind double_ended_queue_unit deq_checker #(
  .DEPTH      (DEPTH),
  .ITEM_WIDTH (ITEM_WIDTH)
) u_deq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// ===== tb/double_ended_queue_unit_tb.sv =====
// Self-checking testbench for the double-ended queue unit: shadow deque, random stalls.
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;

  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IN_W       = ((ITEM_WIDTH + 7) / 8) * 8;
  localparam int OUT_W      = ((2 * ITEM_WIDTH + 2 + CNT_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS    = 14;
  localparam int SEG_ITEMS   = 100;

  // one result beat, unpacked
  typedef struct {
    logic                  status;
    logic [ITEM_WIDTH-1:0] front;
    logic [ITEM_WIDTH-1:0] back;
    logic                  empty;
    logic [CNT_W-1:0]      count;
  } deq_result_t;

  // Shadow deque: tracks ring contents and queues the result each action should give
  class deque_shadow;
    logic [ITEM_WIDTH-1:0] ring [DEPTH];
    int head;
    int fill;
    deq_result_t pending_results[$];
    int mismatches;
    int checked;
    int actions;
    int push_rejects;
    int pop_rejects;
    int looks;
    int peak_fill;

    function new();
      head = 0;
      fill = 0;
      mismatches = 0;
      checked = 0;
      actions = 0;
      push_rejects = 0;
      pop_rejects = 0;
      looks = 0;
      peak_fill = 0;
    endfunction

    // apply one accepted action and queue its result
    function void note_action(logic [2:0] act, logic [IN_W-1:0] val);
      deq_result_t r;
      r.status = deq_pkg::STATUS_OK;
      actions++;
      case (act)
        deq_pkg::ACT_PUSH_FRONT: begin
          if (fill >= DEPTH) begin
            r.status = deq_pkg::STATUS_FAIL;
            push_rejects++;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = val[ITEM_WIDTH-1:0];
            fill++;
          end
        end
        deq_pkg::ACT_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            r.status = deq_pkg::STATUS_FAIL;
            push_rejects++;
          end else begin
            ring[(head + fill) % DEPTH] = val[ITEM_WIDTH-1:0];
            fill++;
          end
        end
        deq_pkg::ACT_POP_FRONT: begin
          if (fill == 0) begin
            r.status = deq_pkg::STATUS_FAIL;
            pop_rejects++;
          end else begin
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
        deq_pkg::ACT_POP_BACK: begin
          if (fill == 0) begin
            r.status = deq_pkg::STATUS_FAIL;
            pop_rejects++;
          end else begin
            fill--;
          end
        end
        // look and the unused codes 5..7 change nothing
        default: looks++;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      r.front = '0;
      r.back  = '0;
      if (fill != 0) begin
        r.front = ring[head];
        r.back  = ring[(head + fill - 1) % DEPTH];
      end
      r.empty = (fill == 0);
      r.count = fill[CNT_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void report_field(string name, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result %0d field %s mismatch: expected %0h, got %0h",
                 $time, checked, name, want, got);
    endfunction

    // compare one result beat with the oldest queued expectation
    function void check_result(logic [OUT_W-1:0] d);
      deq_result_t want;
      deq_result_t got;
      got.status = d[0];
      got.front  = d[ITEM_WIDTH:1];
      got.back   = d[2*ITEM_WIDTH:ITEM_WIDTH+1];
      got.empty  = d[2*ITEM_WIDTH+1];
      got.count  = d[2*ITEM_WIDTH+1+CNT_W:2*ITEM_WIDTH+2];
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat %0h arrived with nothing expected", $time, d);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_field("status", 64'(want.status), 64'(got.status));
      if (got.front !== want.front)
        report_field("front_item", 64'(want.front), 64'(got.front));
      if (got.back !== want.back)
        report_field("back_item", 64'(want.back), 64'(got.back));
      if (got.empty !== want.empty)
        report_field("is_empty", 64'(want.empty), 64'(got.empty));
      if (got.count !== want.count)
        report_field("item_count", 64'(want.count), 64'(got.count));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic [IN_W-1:0]  s_tdata;
  logic [2:0]       s_tuser;
  logic             s_tvalid;
  logic             s_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tvalid;
  logic             m_tready;

  deque_shadow shadow;
  int cycles;
  int tx_gap_pct;
  int rx_stall_pct;

  double_ended_queue_unit #(
    .DEPTH(DEPTH),
    .ITEM_WIDTH(ITEM_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, shadow.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // beat monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) shadow.note_action(s_tuser, s_tdata);
      if (m_tvalid && m_tready) shadow.check_result(m_tdata);
    end
  end

  // result-side backpressure in random bursts
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // present one action beat and hold it until taken
  task automatic send_action(logic [2:0] act, logic [IN_W-1:0] val);
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the sender off until every queued result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] pick_value();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = IN_W'(1) << $urandom_range(0, ITEM_WIDTH - 1);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // push_pct steers the walk toward full or toward empty
  function automatic logic [2:0] pick_action(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 3'($urandom_range(deq_pkg::ACT_LOOK, 7));
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK;
    return $urandom_range(0, 1) ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_BACK;
  endfunction

  initial begin
    int push_pct;
    shadow = new();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= deq_pkg::ACT_LOOK;
    s_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-queue cases, unused codes, then fill to full and overfill
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    send_action(deq_pkg::ACT_LOOK, '1);
    send_action(deq_pkg::ACT_POP_FRONT, '0);
    send_action(deq_pkg::ACT_POP_BACK, '0);
    send_action(3'd5, 'h1234_5678);
    send_action(3'd6, '0);
    send_action(3'd7, '1);
    send_action(deq_pkg::ACT_PUSH_BACK, 'hFFFF_FFFF);
    send_action(deq_pkg::ACT_PUSH_FRONT, '0);
    for (int i = 0; i < DEPTH - 2; i++)
      send_action(i[0] ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT, pick_value());
    send_action(deq_pkg::ACT_PUSH_FRONT, 'hDEAD_BEEF);
    send_action(deq_pkg::ACT_PUSH_BACK, 'hCAFE_F00D);
    drain_results();

    // random walks with changing bias and idling; last segments run flat out
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg >= SEGMENTS - 2) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 10;
          default: tx_gap_pct = 30;
        endcase
        case ($urandom_range(0, 3))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 10;
          default: rx_stall_pct = 35;
        endcase
      end
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (i % 25 == 0) begin
          case ($urandom_range(0, 2))
            0: push_pct = 75;
            1: push_pct = 25;
            default: push_pct = 50;
          endcase
        end
        send_action(pick_action(push_pct), pick_value());
      end
      if (seg == SEGMENTS / 2) drain_results();
    end

    // wait out the tail
    s_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d actions: %0d rejected pushes on full, %0d rejected pops on empty, %0d looks",
             shadow.actions, shadow.push_rejects, shadow.pop_rejects, shadow.looks);
    $display("Peak occupancy %0d of %0d, %0d results checked, %0d mismatches",
             shadow.peak_fill, DEPTH, shadow.checked, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue_unit.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/deq_chain.sv
hw/rtl/double_ended_queue_unit.sv
hw/rtl/deq_checker.sv
tb/double_ended_queue_unit_tb.sv
